FILE: src/tmm_pkg.sv
package tmm_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int POS_W       = 32;
  localparam int SONG_W      = 32;
  localparam int BEAT_W      = 24;
  localparam int BAR_W       = 6;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Metronome pulse
  localparam int PULSE_LEN   = 96;
  localparam int PH_W        = $clog2(PULSE_LEN);
  localparam int FULL_SCALE  = 1 << (SAMPLE_BITS - 1);
  localparam int ACCENT_HI   = (FULL_SCALE * 20 + 50) / 100;
  localparam int ACCENT_LO   = (FULL_SCALE * 12 + 50) / 100;
  localparam int CLICK_W     = $clog2(ACCENT_HI + 1);

  // One quotient bit per cycle over the whole playhead
  localparam int DIV_STEPS   = POS_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  localparam logic [SONG_W-1:0] SONG_LENGTH_RST = '0;
  localparam logic [BEAT_W-1:0] BEAT_LENGTH_RST = BEAT_W'(24000);
  localparam logic [BAR_W-1:0]  BAR_BEATS_RST   = BAR_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_FRAME  = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_SETPOS = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SONG_LENGTH  = 3'd0,
    REG_BEAT_LENGTH  = 3'd1,
    REG_BAR_BEATS    = 3'd2,
    REG_LOOP_ENABLE  = 3'd3,
    REG_CLICK_ENABLE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [OP_W-1:0]               operation;
    logic                          block_start;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic signed [POS_W-1:0]       new_position;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          is_playing;
  } out_item_t;

  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic step;    // one divider iteration
    logic mix;     // write result, advance playhead
  } tmm_cmd_t;

  typedef struct packed {
    logic out_free;
  } tmm_sts_t;

  typedef logic [PULSE_LEN-1:0][CLICK_W-1:0] click_tab_t;

  // Decaying click shape, rounded; evaluated at elaboration only
  function automatic click_tab_t click_tab(input int amp);
    click_tab_t t;
    for (int i = 0; i < PULSE_LEN; i++) begin
      t[i] = CLICK_W'((amp * (PULSE_LEN - i) + PULSE_LEN / 2) / PULSE_LEN);
    end
    return t;
  endfunction

endpackage

FILE: src/transport_metronome_mixer_unit.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_ready     | in_data   (tmm_pkg::in_item_t)
// out     | output    | out_valid / out_ready   | out_data  (tmm_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Audio frame items: after accept, 32 iterations of the restoring divider (one
// quotient bit per cycle over the 32-bit playhead, bar position reduced alongside),
// then a mix step that registers the result; no new item is taken until the cycle
// after the mix. Control items are applied on accept and leave the input ready.
// Reset is synchronous active low; no clearing pass. cfg_ready is always high.
// A full output register stalls the mix step; input is taken again once it lands.
module transport_metronome_mixer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tmm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tmm_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmm_pkg::*;

  tmm_cmd_t cmd;
  tmm_sts_t sts;

  assign cfg_ready = 1'b1;

  tmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/tmm_ctrl.sv
module tmm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [tmm_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  tmm_pkg::tmm_sts_t        sts,
  output tmm_pkg::tmm_cmd_t        cmd
);
  import tmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_MIX  = 3'b100
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state_r == S_DIV);
  assign cmd.mix    = (state_r == S_MIX) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && in_op == OP_FRAME) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_frame_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_op == OP_FRAME |=> state_r == S_DIV && cnt_r == '0)
    else $error("frame item did not start the divider");

  a_div_ends_in_mix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == CNT_LAST |=> state_r == S_MIX)
    else $error("divider did not finish after the last step");

  a_mix_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MIX && !sts.out_free |=> state_r == S_MIX)
    else $error("result dropped while output register full");
`endif

endmodule

FILE: src/tmm_dp.sv
module tmm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tmm_pkg::in_item_t              in_data,
  input  logic                           cfg_valid,
  input  logic [tmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  tmm_pkg::tmm_cmd_t              cmd,
  output tmm_pkg::tmm_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tmm_pkg::out_item_t             out_data
);
  import tmm_pkg::*;

  localparam click_tab_t TAB_ACCENT = click_tab(ACCENT_HI);
  localparam click_tab_t TAB_BEAT   = click_tab(ACCENT_LO);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration
  logic [SONG_W-1:0] song_length_r;
  logic [BEAT_W-1:0] beat_length_r;
  logic [BAR_W-1:0]  bar_beats_r;
  logic              loop_enable_r;
  logic              click_enable_r;

  // Transport
  logic              running_r, running_nxt;
  logic [POS_W-1:0]  position_r, position_nxt;

  // Divider: position / beat, quotient mod bar folded in MSB first
  logic [POS_W-1:0]  quo_r, quo_nxt;
  logic [BEAT_W-1:0] rem_r, rem_nxt;
  logic [BAR_W-1:0]  bar_r, bar_nxt;
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [BEAT_W-1:0] bl_eff;
  logic [BAR_W-1:0]  bb_eff;
  logic [BEAT_W:0]   trial, trial_sub;
  logic              qbit;
  logic [BAR_W:0]    btrial, btrial_sub;
  logic              in_pulse;
  logic [PH_W-1:0]   ph_idx;
  logic [CLICK_W-1:0] click;
  logic              song_end;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_add(
    input logic signed [SAMPLE_BITS-1:0] smp,
    input logic [CLICK_W-1:0]            clk_amp
  );
    logic signed [SAMPLE_BITS:0] s;
    s = {smp[SAMPLE_BITS-1], smp} + $signed({{(SAMPLE_BITS+1-CLICK_W){1'b0}}, clk_amp});
    if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) begin
      return s[SAMPLE_BITS] ? SMP_MIN : SMP_MAX;
    end
    return s[SAMPLE_BITS-1:0];
  endfunction

  assign bl_eff = (beat_length_r == '0) ? BEAT_W'(1) : beat_length_r;
  assign bb_eff = (bar_beats_r == '0) ? BAR_W'(1) : bar_beats_r;

  assign trial      = {rem_r, quo_r[POS_W-1]};
  assign trial_sub  = trial - {1'b0, bl_eff};
  assign qbit       = (trial >= {1'b0, bl_eff});
  assign btrial     = {bar_r, qbit};
  assign btrial_sub = btrial - {1'b0, bb_eff};

  assign in_pulse = (rem_r < BEAT_W'(PULSE_LEN));
  assign ph_idx   = rem_r[PH_W-1:0];
  assign click    = !(click_enable_r && in_pulse) ? '0 :
                    (bar_r == '0) ? TAB_ACCENT[ph_idx] : TAB_BEAT[ph_idx];

  assign song_end = running_r && in_data.block_start && song_length_r != '0 &&
                    position_r >= song_length_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_item_r;

  always_comb begin
    running_nxt   = running_r;
    position_nxt  = position_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bar_nxt       = bar_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.accept) begin
      unique case (in_data.operation)
        OP_TOGGLE: running_nxt = !running_r;
        OP_SETPOS: position_nxt = in_data.new_position[POS_W-1] ? '0 : in_data.new_position;
        OP_FRAME: begin
          if (song_end) begin
            if (loop_enable_r) begin
              position_nxt = '0;
            end else begin
              running_nxt = 1'b0;
            end
          end
          quo_nxt = (song_end && loop_enable_r) ? '0 : position_r;
          rem_nxt = '0;
          bar_nxt = '0;
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      quo_nxt = {quo_r[POS_W-2:0], qbit};
      rem_nxt = qbit ? trial_sub[BEAT_W-1:0] : trial[BEAT_W-1:0];
      bar_nxt = (btrial >= {1'b0, bb_eff}) ? btrial_sub[BAR_W-1:0] : btrial[BAR_W-1:0];
    end

    if (cmd.mix) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.is_playing = running_r;
      out_item_nxt.left_out   = running_r ? sat_add(left_r, click) : '0;
      out_item_nxt.right_out  = running_r ? sat_add(right_r, click) : '0;
      if (running_r && position_r != '1) begin
        position_nxt = position_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_length_r  <= SONG_LENGTH_RST;
      beat_length_r  <= BEAT_LENGTH_RST;
      bar_beats_r    <= BAR_BEATS_RST;
      loop_enable_r  <= 1'b0;
      click_enable_r <= 1'b0;
      running_r      <= 1'b0;
      position_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      position_r  <= position_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SONG_LENGTH:  song_length_r  <= cfg_data[SONG_W-1:0];
          REG_BEAT_LENGTH:  beat_length_r  <= cfg_data[BEAT_W-1:0];
          REG_BAR_BEATS:    bar_beats_r    <= cfg_data[BAR_W-1:0];
          REG_LOOP_ENABLE:  loop_enable_r  <= cfg_data[0];
          REG_CLICK_ENABLE: click_enable_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    bar_r      <= bar_nxt;
    out_item_r <= out_item_nxt;
    if (cmd.accept) begin
      left_r  <= in_data.left_in;
      right_r <= in_data.right_in;
    end
  end

`ifndef ASSERT_OFF
  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.mix))
    else $error("result appeared without a mix");

  a_playhead_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix && running_r && position_r != '1 |=> position_r == $past(position_r) + 1'b1)
    else $error("playhead did not advance on a running frame");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_item_r))
    else $error("waiting result changed or dropped");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tmm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int unsigned     PULSE_SAMPS  = 96;
  localparam longint unsigned ACC_DOWNBEAT = 6554;  // 0.20 full scale
  localparam longint unsigned ACC_BEAT     = 3932;  // 0.12 full scale
  localparam int              DRAIN_CYCLES = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // transport model state and register copy
  logic        playing;
  logic [31:0] playhead;
  logic [31:0] song_len;
  logic [23:0] beat_len;
  logic [5:0]  bar_len;
  logic        loop_en;
  logic        click_en;

  out_item_t expected_mix_q[$];
  int        errors;
  bit        tx_gaps;
  bit        rx_stalls;
  int        rx_hold;

  transport_metronome_mixer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int click_amp(input logic [31:0] pos);
    int unsigned bl;
    int unsigned bb;
    int unsigned phase;
    longint unsigned acc;
    bl = (beat_len == 0) ? 1 : beat_len;
    bb = (bar_len == 0) ? 1 : bar_len;
    phase = pos % bl;
    if (phase >= PULSE_SAMPS) return 0;
    acc = (((pos / bl) % bb) == 0) ? ACC_DOWNBEAT : ACC_BEAT;
    return int'((acc * (PULSE_SAMPS - phase) + PULSE_SAMPS / 2) / PULSE_SAMPS);
  endfunction

  // one audio frame through the transport; updates the model state
  function automatic out_item_t mix_frame(input in_item_t it);
    out_item_t o;
    int click;
    int l;
    int r;
    o = '0;
    if (playing && it.block_start && song_len != 0 && playhead >= song_len) begin
      if (loop_en) playhead = '0;
      else playing = 1'b0;
    end
    if (playing) begin
      click = click_en ? click_amp(playhead) : 0;
      l = it.left_in;
      r = it.right_in;
      o.left_out = sat16(l + click);
      o.right_out = sat16(r + click);
      if (playhead != 32'hffff_ffff) playhead = playhead + 1;
    end
    o.is_playing = playing;
    return o;
  endfunction

  function automatic in_item_t make_item(input logic [OP_W-1:0] op, input logic bs,
                                         input int l, input int r, input int pos);
    in_item_t it;
    it.operation = op;
    it.block_start = bs;
    it.left_in = 16'(l);
    it.right_in = 16'(r);
    it.new_position = pos;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (it.operation)
      OP_FRAME:  expected_mix_q.push_back(mix_frame(it));
      OP_TOGGLE: playing = !playing;
      OP_SETPOS: playhead = (it.new_position < 0) ? 32'd0 : it.new_position;
      default: ;
    endcase
  endtask

  // sender stops and waits for every result, plus settle time
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_mix_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] data;
    case (idx)
      REG_BEAT_LENGTH: mask = 32'h00ff_ffff;
      REG_BAR_BEATS:   mask = 32'h0000_003f;
      REG_LOOP_ENABLE, REG_CLICK_ENABLE: mask = 32'h1;
      default:         mask = 32'hffff_ffff;
    endcase
    data = val & mask;
    // unused upper bits must be ignored
    if ($urandom_range(0, 1) != 0) data = data | ($urandom() & ~mask);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SONG_LENGTH:  song_len = data;
      REG_BEAT_LENGTH:  beat_len = data[23:0];
      REG_BAR_BEATS:    bar_len = data[5:0];
      REG_LOOP_ENABLE:  loop_en = data[0];
      REG_CLICK_ENABLE: click_en = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] song, input logic [31:0] beat,
                               input logic [31:0] bar, input bit loop, input bit click);
    wait_idle();
    write_reg(REG_SONG_LENGTH, song);
    write_reg(REG_BEAT_LENGTH, beat);
    write_reg(REG_BAR_BEATS, bar);
    write_reg(REG_LOOP_ENABLE, loop);
    write_reg(REG_CLICK_ENABLE, click);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 5))
      0: return 32767;
      1: return -32768;
      2: return 32767 - int'($urandom_range(0, 7000));
      3: return -32768 + int'($urandom_range(0, 100));
      default: return int'($urandom() & 16'hffff);
    endcase
  endfunction

  function automatic in_item_t rand_item(input int unsigned span);
    in_item_t it;
    int unsigned r;
    int unsigned bl;
    bl = (beat_len == 0) ? 1 : beat_len;
    it = make_item(OP_FRAME, $urandom_range(0, 3) == 0, rand_sample(), rand_sample(),
                   $urandom());
    r = $urandom_range(0, 99);
    if (r < 4) begin
      it.operation = OP_TOGGLE;
    end else if (r < 10) begin
      it.operation = OP_SETPOS;
      case ($urandom_range(0, 4))
        0: ;  // full 32-bit value, negative half clamps
        1: it.new_position = $urandom_range(0, span);
        2: it.new_position = $urandom_range(0, 40) * bl + $urandom_range(0, 100);
        3: it.new_position = song_len - $urandom_range(0, 3);
        default: it.new_position = $urandom_range(0, 200);
      endcase
    end else if (r < 12) begin
      it.operation = OP_UNUSED;
    end
    // mostly keep the transport running so frames reach the mixer
    if (!playing && $urandom_range(0, 3) != 0) it.operation = OP_TOGGLE;
    return it;
  endfunction

  task automatic run_random(input int n, input int unsigned span);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
      end
      send_item(rand_item(span));
    end
  endtask

  task automatic test_stopped_after_reset();
    send_item(make_item(OP_FRAME, 1'b1, 32767, -32768, 0));
    send_item(make_item(OP_UNUSED, 1'b1, -1, -1, -1));
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 32'h8000_0000));
    send_item(make_item(OP_TOGGLE, 1'b0, 0, 0, 0));
    send_item(make_item(OP_FRAME, 1'b0, 32767, -32768, 0));
    send_item(make_item(OP_FRAME, 1'b1, -1, 1, 0));
    wait_idle();
  endtask

  task automatic test_click_shape();
    write_reg(REG_BEAT_LENGTH, 100);
    write_reg(REG_BAR_BEATS, 2);
    write_reg(REG_CLICK_ENABLE, 1);
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 0));
    send_item(make_item(OP_FRAME, 1'b0, 32767, -32768, 0));
    // pulse tail and the first sample past it
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 94));
    repeat (3) send_item(make_item(OP_FRAME, 1'b0, 1000, -1000, 0));
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 100));
    send_item(make_item(OP_FRAME, 1'b0, 0, 32000, 0));
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 200));
    send_item(make_item(OP_FRAME, 1'b1, -32768, 0, 0));
    wait_idle();
  endtask

  task automatic test_song_end();
    write_reg(REG_SONG_LENGTH, 5);
    write_reg(REG_LOOP_ENABLE, 0);
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 7));
    send_item(make_item(OP_FRAME, 1'b0, 5, 6, 0));
    send_item(make_item(OP_FRAME, 1'b1, 5, 6, 0));
    send_item(make_item(OP_TOGGLE, 1'b0, 0, 0, 0));
    send_item(make_item(OP_SETPOS, 1'b0, 0, 0, 4));
    send_item(make_item(OP_FRAME, 1'b1, 7, 8, 0));
    send_item(make_item(OP_FRAME, 1'b1, 7, 8, 0));
    wait_idle();
    write_reg(REG_LOOP_ENABLE, 1);
    send_item(make_item(OP_TOGGLE, 1'b0, 0, 0, 0));
    send_item(make_item(OP_FRAME, 1'b1, 9, -9, 0));
    wait_idle();
  endtask

  task automatic test_backpressure();
    apply_setting(0, 10, 4, 0, 1);
    if (!playing) send_item(make_item(OP_TOGGLE, 1'b0, 0, 0, 0));
    tx_gaps = 1'b0;
    rx_hold = 400;
    repeat (40) send_item(make_item(OP_FRAME, 1'($urandom_range(0, 1)), rand_sample(),
                                    rand_sample(), 0));
    wait_idle();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_random_settings();
    apply_setting(0, 24000, 4, 0, 1);
    run_random(190, 100000);
    apply_setting(200, 1, 1, 1, 1);
    run_random(190, 260);
    apply_setting(150, 0, 0, 0, 1);  // zero beat and bar act as one
    run_random(190, 200);
    wait_idle();
    rx_hold = 250;
    run_random(20, 200);
    apply_setting(32'hffff_ffff, 32'h00ff_ffff, 32, 1, 1);
    run_random(190, 32'hffff_ffff);
    apply_setting(1000, 97, 63, 1, 1);
    run_random(190, 1200);
    apply_setting(300, 37, 5, 0, 0);
    run_random(190, 400);
    apply_setting(1, 2, 3, 1, 1);
    run_random(190, 10);
    wait_idle();
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        out_ready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      stall = rx_stalls ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_mix;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mix_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        exp_mix = expected_mix_q.pop_front();
        if (out_data.left_out !== exp_mix.left_out)
          report_mismatch($sformatf("left_out got %0d exp %0d",
                                    out_data.left_out, exp_mix.left_out));
        if (out_data.right_out !== exp_mix.right_out)
          report_mismatch($sformatf("right_out got %0d exp %0d",
                                    out_data.right_out, exp_mix.right_out));
        if (out_data.is_playing !== exp_mix.is_playing)
          report_mismatch($sformatf("is_playing got %b exp %b",
                                    out_data.is_playing, exp_mix.is_playing));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    rx_hold = 0;
    playing = 1'b0;
    playhead = '0;
    song_len = '0;
    beat_len = 24'd24000;
    bar_len = 6'd4;
    loop_en = 1'b0;
    click_en = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_stopped_after_reset();
    test_click_shape();
    test_song_end();
    test_backpressure();
    test_random_settings();
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
